// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decoder's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is switched off while reset is applied.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/qoi_dec_pkg.sv =====
// Types and constants shared by the image stream decoder's modules.
package qoi_dec_pkg;

  localparam int COUNT_W     = 25;
  localparam int INDEX_DEPTH = 64;
  localparam int INDEX_W     = 6;
  localparam int MAX_RUN     = 62;
  localparam int RUN_W       = 6;
  localparam int PAD_LEN     = 8;
  localparam int PHASE_W     = 4;

  localparam logic [7:0] BYTE_RGB  = 8'hFE;
  localparam logic [7:0] BYTE_RGBA = 8'hFF;

  localparam logic [31:0] PIXEL_RESET = 32'h0000_00FF;

  localparam logic [1:0] ST_PIXEL   = 2'd0;
  localparam logic [1:0] ST_PAD_OK  = 2'd1;
  localparam logic [1:0] ST_PAD_BAD = 2'd2;

  // Work handed from the front end to the back end.
  typedef enum logic [2:0] {
    K_RGB,
    K_RGBA,
    K_INDEX,
    K_ADD,
    K_RUN,
    K_STATUS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [31:0]        data;
    logic [RUN_W-1:0]   count;
    logic               ends_image;
  } cmd_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_RGB,
    PEND_RGBA,
    PEND_LUMA
  } pend_op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_INDEX,
    B_RUN
  } back_state_t;

endpackage

// ===== rtl/core/qoi_dec_front.sv =====
// Front end: parses chunk bytes, tracks remaining pixels and the end padding.
module qoi_dec_front
  import qoi_dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_stream_byte,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  pend_op_t           pend_r, pend_nxt;
  logic [2:0]         nheld_r, nheld_nxt;
  logic [31:0]        held_r, held_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               bad_r, bad_nxt;

  logic               accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic       done;
    logic [7:0] dg, dr, db, want;
    logic       bad_now;
    logic [6:0] len;
    pend_nxt  = pend_r;
    nheld_nxt = nheld_r;
    held_nxt  = held_r;
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    bad_nxt   = bad_r;
    q_push    = 1'b0;
    q_cmd     = '0;
    done      = 1'b0;
    dg        = {2'b00, held_r[5:0]} - 8'd32;
    dr        = dg - 8'd8 + {4'h0, in_stream_byte[7:4]};
    db        = dg - 8'd8 + {4'h0, in_stream_byte[3:0]};
    want      = (phase_r == PHASE_W'(PAD_LEN - 1)) ? 8'd1 : 8'd0;
    bad_now   = bad_r || (in_stream_byte != want);
    len       = {1'b0, in_stream_byte[5:0]} + 7'd1;
    if (len > 7'(MAX_RUN)) begin
      len = 7'(MAX_RUN);
    end
    if (accept) begin
      if (pend_r != PEND_NONE) begin
        held_nxt  = {held_r[23:0], in_stream_byte};
        nheld_nxt = nheld_r + 3'd1;
        case (pend_r)
          PEND_RGB: begin
            done       = (nheld_r == 3'd2);
            q_cmd.kind = K_RGB;
            q_cmd.data = {8'h00, held_r[15:0], in_stream_byte};
          end
          PEND_RGBA: begin
            done       = (nheld_r == 3'd3);
            q_cmd.kind = K_RGBA;
            q_cmd.data = {held_r[23:0], in_stream_byte};
          end
          PEND_LUMA: begin
            done       = (nheld_r == 3'd1);
            q_cmd.kind = K_ADD;
            q_cmd.data = {dr, dg, db, 8'h00};
          end
          default: begin
            done = 1'b0;
          end
        endcase
        if (done) begin
          q_push           = 1'b1;
          q_cmd.ends_image = (rem_r == COUNT_W'(1));
          rem_nxt          = rem_r - COUNT_W'(1);
          pend_nxt         = PEND_NONE;
          held_nxt         = '0;
          nheld_nxt        = '0;
        end
      end else if (rem_r == '0) begin
        if (phase_r < PHASE_W'(PAD_LEN)) begin
          bad_nxt   = bad_now;
          phase_nxt = phase_r + PHASE_W'(1);
          if (phase_r == PHASE_W'(PAD_LEN - 1)) begin
            q_push        = 1'b1;
            q_cmd.kind    = K_STATUS;
            q_cmd.data[0] = bad_now;
          end
        end
      end else if (in_stream_byte == BYTE_RGB || in_stream_byte == BYTE_RGBA) begin
        pend_nxt  = (in_stream_byte == BYTE_RGB) ? PEND_RGB : PEND_RGBA;
        held_nxt  = '0;
        nheld_nxt = '0;
      end else begin
        case (in_stream_byte[7:6])
          2'b00: begin
            q_push           = 1'b1;
            q_cmd.kind       = K_INDEX;
            q_cmd.data       = {26'd0, in_stream_byte[5:0]};
            q_cmd.ends_image = (rem_r == COUNT_W'(1));
            rem_nxt          = rem_r - COUNT_W'(1);
          end
          2'b01: begin
            q_push           = 1'b1;
            q_cmd.kind       = K_ADD;
            q_cmd.data       = {{6'd0, in_stream_byte[5:4]} - 8'd2,
                                {6'd0, in_stream_byte[3:2]} - 8'd2,
                                {6'd0, in_stream_byte[1:0]} - 8'd2, 8'h00};
            q_cmd.ends_image = (rem_r == COUNT_W'(1));
            rem_nxt          = rem_r - COUNT_W'(1);
          end
          2'b10: begin
            pend_nxt  = PEND_LUMA;
            held_nxt  = {24'd0, in_stream_byte};
            nheld_nxt = 3'd1;
          end
          default: begin
            q_push     = 1'b1;
            q_cmd.kind = K_RUN;
            if (rem_r <= COUNT_W'(len)) begin
              q_cmd.count      = rem_r[RUN_W-1:0];
              q_cmd.ends_image = 1'b1;
              rem_nxt          = '0;
            end else begin
              q_cmd.count      = len[RUN_W-1:0];
              q_cmd.ends_image = 1'b0;
              rem_nxt          = rem_r - COUNT_W'(len);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PEND_NONE;
      nheld_r <= '0;
      held_r  <= '0;
      rem_r   <= '0;
      phase_r <= '0;
      bad_r   <= 1'b0;
    end else if (cfg_we) begin
      pend_r  <= PEND_NONE;
      nheld_r <= '0;
      held_r  <= '0;
      rem_r   <= cfg_wdata;
      phase_r <= '0;
      bad_r   <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      nheld_r <= nheld_nxt;
      held_r  <= held_nxt;
      rem_r   <= rem_nxt;
      phase_r <= phase_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

// ===== rtl/core/qoi_dec_fifo.sv =====
// Short command queue between the front end and the back end.
`include "assert_macros.svh"

module qoi_dec_fifo
  import qoi_dec_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic clr,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_r <= CNT_W'(DEPTH)))
  `ASSERT_CLK(a_push_counts, clk, rst_n,
              (push && !pop && !clr) |=> (count_r == $past(count_r) + CNT_W'(1)))
  `ASSERT_CLK(a_pop_counts, clk, rst_n,
              (pop && !push && !clr) |=> (count_r == $past(count_r) - CNT_W'(1)))

endmodule

// ===== rtl/core/qoi_dec_back.sv =====
// Back end: holds the previous pixel and index table and emits results.
`include "assert_macros.svh"

module qoi_dec_back
  import qoi_dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_pixel,
  output logic        out_last_of_run,
  output logic        out_last_of_image
);

  function automatic logic [INDEX_W-1:0] pixel_hash(input logic [31:0] p);
    logic [INDEX_W-1:0] r, g, b, a;
    r = p[24 +: INDEX_W];
    g = p[16 +: INDEX_W];
    b = p[8 +: INDEX_W];
    a = p[0 +: INDEX_W];
    return (r * INDEX_W'(3)) + (g * INDEX_W'(5)) + (b * INDEX_W'(7)) + (a * INDEX_W'(11));
  endfunction

  back_state_t        state_r, state_nxt;
  logic [31:0]        prev_r;
  logic [RUN_W-1:0]   run_left_r;
  logic               hold_end_r;
  logic [31:0]        rd_data_r;
  logic               rd_valid_r;
  logic [INDEX_DEPTH-1:0] valid_r;
  logic [31:0]        index_mem [INDEX_DEPTH];

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [31:0]        out_pixel_r;
  logic               out_last_run_r;
  logic               out_last_img_r;

  logic               out_free;
  logic               emit;
  logic               emit_pixel;
  logic [1:0]         emit_status;
  logic [31:0]        pix_new;
  logic               emit_last_run;
  logic               emit_last_img;
  logic               rd_en;
  logic               hold_load;
  logic [INDEX_W-1:0] wr_addr;

  assign out_free = !out_valid_r || out_ready;
  assign wr_addr  = pixel_hash(pix_new);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid && cmd.kind == K_INDEX) begin
          state_nxt = B_INDEX;
        end else if (cmd_valid && cmd.kind == K_RUN) begin
          state_nxt = B_RUN;
        end
      end
      B_INDEX: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      B_RUN: begin
        if (out_free && run_left_r == RUN_W'(1)) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cmd_pop       = 1'b0;
    emit          = 1'b0;
    emit_pixel    = 1'b0;
    emit_status   = ST_PIXEL;
    pix_new       = prev_r;
    emit_last_run = 1'b1;
    emit_last_img = 1'b0;
    rd_en         = 1'b0;
    hold_load     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_INDEX: begin
              cmd_pop   = 1'b1;
              rd_en     = 1'b1;
              hold_load = 1'b1;
            end
            K_RUN: begin
              cmd_pop   = 1'b1;
              hold_load = 1'b1;
            end
            K_STATUS: begin
              if (out_free) begin
                cmd_pop     = 1'b1;
                emit        = 1'b1;
                emit_status = cmd.data[0] ? ST_PAD_BAD : ST_PAD_OK;
              end
            end
            default: begin
              if (out_free) begin
                cmd_pop       = 1'b1;
                emit          = 1'b1;
                emit_pixel    = 1'b1;
                emit_last_img = cmd.ends_image;
                if (cmd.kind == K_RGB) begin
                  pix_new = {cmd.data[23:0], prev_r[7:0]};
                end else if (cmd.kind == K_RGBA) begin
                  pix_new = cmd.data;
                end else begin
                  pix_new = {prev_r[31:24] + cmd.data[31:24],
                             prev_r[23:16] + cmd.data[23:16],
                             prev_r[15:8] + cmd.data[15:8], prev_r[7:0]};
                end
              end
            end
          endcase
        end
      end
      B_INDEX: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_pixel    = 1'b1;
          pix_new       = rd_valid_r ? rd_data_r : '0;
          emit_last_img = hold_end_r;
        end
      end
      B_RUN: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_pixel    = 1'b1;
          emit_last_run = (run_left_r == RUN_W'(1));
          emit_last_img = (run_left_r == RUN_W'(1)) && hold_end_r;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Index table storage and its registered read port.
  always_ff @(posedge clk) begin
    if (emit_pixel) begin
      index_mem[wr_addr] <= pix_new;
    end
    if (rd_en) begin
      rd_data_r <= index_mem[cmd.data[INDEX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r    <= B_IDLE;
      prev_r     <= PIXEL_RESET;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      run_left_r <= '0;
      hold_end_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_pixel) begin
        prev_r           <= pix_new;
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[cmd.data[INDEX_W-1:0]];
      end
      if (hold_load) begin
        run_left_r <= cmd.count;
        hold_end_r <= cmd.ends_image;
      end else if (state_r == B_RUN && out_free) begin
        run_left_r <= run_left_r - RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r   <= emit_status;
      out_pixel_r    <= emit_pixel ? pix_new : '0;
      out_last_run_r <= emit_last_run;
      out_last_img_r <= emit_last_img;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_pixel         = out_pixel_r;
  assign out_last_of_run   = out_last_run_r;
  assign out_last_of_image = out_last_img_r;

  `ASSERT_CLK(a_run_nonzero, clk, rst_n, (state_r == B_RUN) |-> (run_left_r != '0))
  `ASSERT_CLK(a_status_flags, clk, rst_n,
              (out_valid_r && out_status_r != ST_PIXEL) |-> (out_last_run_r && !out_last_img_r))
  `ASSERT_CLK(a_table_marked, clk, rst_n,
              (emit_pixel && !cfg_we) |=> valid_r[$past(wr_addr)])

endmodule

// ===== rtl/core/qoi_pixel_stream_decoder.sv =====
// Top level of the chunk stream decoder: front end, command queue, back end.

// This block decodes the chunk stream of an image in the common lossless
// "quite OK" format, one byte per input transaction, starting right after the
// 14-byte file header, and produces RGBA pixels on the result channel. Software
// parses the header itself and writes width times height to cfg_wdata with
// cfg_we; that write also starts a new image, clearing the previous pixel (to
// opaque black), the 64-entry index table, any partial chunk and the padding
// check. It must only be issued while the block is idle. Once every pixel has
// been produced, the next eight bytes are checked against the end marker and a
// single status transaction (out_status 1 matched, 2 mismatch) reports the
// result; further bytes are consumed without a result. A run chunk is cut short
// at the image's last pixel.
//
// Flow: the front end takes one byte per cycle as long as its command queue
// (QUEUE_DEPTH entries) has room. The back end emits an RGB, RGBA, DIFF or
// LUMA pixel, or a padding status, as it pops the command; an INDEX command
// is popped while the index table, which has a registered read port, is read,
// and its pixel is emitted from the INDEX state; a run is loaded when popped
// and then yields one pixel per cycle while the output register is free. The
// front end keeps accepting bytes during a run until the queue is full. The
// output register holds a finished result until out_ready; while it waits the
// back end stalls, and the front end keeps taking bytes until the queue is full.
module qoi_pixel_stream_decoder
  import qoi_dec_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_stream_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic               out_last_of_run,
  output logic               out_last_of_image
);

  // Commands travel from the front end to the back end through the queue.
  logic  q_push;
  cmd_t  q_push_cmd;
  logic  q_full;
  logic  q_pop;
  logic  q_not_empty;
  cmd_t  q_head_cmd;
  logic [31:0] pixel;

  // The front end parses chunks and keeps its own count of pixels still to be
  // scheduled, so it decides alone when the stream moves on to the padding.
  qoi_dec_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd)
  );

  qoi_dec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_we),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head_cmd)
  );

  // The back end owns the pixel state and the output register.
  qoi_dec_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cmd_valid         (q_not_empty),
    .cmd               (q_head_cmd),
    .cmd_pop           (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_pixel         (pixel),
    .out_last_of_run   (out_last_of_run),
    .out_last_of_image (out_last_of_image)
  );

  // The pixel word is packed red in the top byte down to alpha in the bottom.
  assign out_red   = pixel[31:24];
  assign out_green = pixel[23:16];
  assign out_blue  = pixel[15:8];
  assign out_alpha = pixel[7:0];

endmodule

// ===== test/tb_qoi_pixel_stream_decoder.sv =====
// Self-checking testbench for the QOI chunk stream decoder, with its own scoreboard.
`timescale 1ns / 1ps

module tb_qoi_pixel_stream_decoder
  import qoi_dec_pkg::*;
();

  // Accepted stream bytes after which no further random image is started.
  localparam int RANDOM_BYTES  = 370;
  // Cycles allowed for the block to drain bytes that cause no result
  // (partial chunks, bytes after the padding) before a new image is started.
  localparam int SETTLE_CYCLES = 40;
  // Byte budget of an image whose pixel count is too large to finish.
  localparam int HUGE_IMAGE_BYTES = 40;
  localparam logic [COUNT_W-1:0] MAX_COUNT = 25'd16777216;

  // One result transaction, field by field.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_run;
    logic       last_of_image;
  } pixel_result_t;

  // The scoreboard decodes every accepted byte on its own copy of the decoder
  // state and keeps the pixels and status results that the block still owes.
  class decode_scoreboard;
    logic [COUNT_W-1:0] remaining;
    logic [31:0]        prev_pixel;
    logic [31:0]        color_index [INDEX_DEPTH];
    pend_op_t           pend;
    int                 held_count;
    logic [31:0]        held_bytes;
    int                 pad_phase;
    bit                 pad_bad;
    pixel_result_t      owed_results [$];
    int                 used_slots [$];
    int                 errors;

    function new();
      errors    = 0;
      remaining = '0;
      start_image();
    endfunction

    function void start_image();
      prev_pixel = PIXEL_RESET;
      foreach (color_index[i]) color_index[i] = '0;
      pend       = PEND_NONE;
      held_count = 0;
      held_bytes = '0;
      pad_phase  = 0;
      pad_bad    = 1'b0;
      used_slots.delete();
    endfunction

    // A write of the pixel count starts a new image.
    function void load_count(logic [COUNT_W-1:0] count);
      remaining = count;
      start_image();
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // Every pixel that leaves is stored in the color index and owed as a result.
    function void emit_pixel(bit run_end);
      pixel_result_t res;
      int slot;
      slot = (int'(prev_pixel[31:24]) * 3 + int'(prev_pixel[23:16]) * 5 +
              int'(prev_pixel[15:8]) * 7 + int'(prev_pixel[7:0]) * 11) % INDEX_DEPTH;
      color_index[slot] = prev_pixel;
      used_slots.push_back(slot);
      if (used_slots.size() > INDEX_DEPTH) void'(used_slots.pop_front());
      if (remaining != 0) remaining = remaining - 1'b1;
      res.status        = ST_PIXEL;
      res.red           = prev_pixel[31:24];
      res.green         = prev_pixel[23:16];
      res.blue          = prev_pixel[15:8];
      res.alpha         = prev_pixel[7:0];
      res.last_of_run   = run_end;
      res.last_of_image = (remaining == 0);
      owed_results.push_back(res);
    endfunction

    // Called once per accepted input transaction.
    function void note_byte(logic [7:0] data);
      logic [7:0] r, g, b, a, dg, lo;
      pixel_result_t res;
      int run_len;
      r = prev_pixel[31:24];
      g = prev_pixel[23:16];
      b = prev_pixel[15:8];
      a = prev_pixel[7:0];

      // A multi-byte chunk collects its bytes and emits only on the last one.
      if (pend != PEND_NONE) begin
        held_bytes = {held_bytes[23:0], data};
        held_count++;
        if (pend == PEND_RGB && held_count == 3) begin
          prev_pixel = {held_bytes[23:0], a};
        end else if (pend == PEND_RGBA && held_count == 4) begin
          prev_pixel = held_bytes;
        end else if (pend == PEND_LUMA && held_count == 2) begin
          dg = {2'b00, held_bytes[13:8]} - 8'd32;
          lo = held_bytes[7:0];
          prev_pixel = {8'(r + dg - 8'd8 + {4'b0000, lo[7:4]}), 8'(g + dg),
                        8'(b + dg - 8'd8 + {4'b0000, lo[3:0]}), a};
        end else begin
          return;
        end
        pend       = PEND_NONE;
        held_count = 0;
        held_bytes = '0;
        emit_pixel(1'b1);
        return;
      end

      // Once the image is complete the bytes are the end marker, then ignored.
      if (remaining == 0) begin
        if (pad_phase >= PAD_LEN) return;
        if (data != ((pad_phase == PAD_LEN - 1) ? 8'd1 : 8'd0)) pad_bad = 1'b1;
        pad_phase++;
        if (pad_phase < PAD_LEN) return;
        res               = '0;
        res.status        = pad_bad ? ST_PAD_BAD : ST_PAD_OK;
        res.last_of_run   = 1'b1;
        owed_results.push_back(res);
        return;
      end

      if (data == BYTE_RGB || data == BYTE_RGBA) begin
        pend       = (data == BYTE_RGB) ? PEND_RGB : PEND_RGBA;
        held_count = 0;
        held_bytes = '0;
      end else if (data < 8'd64) begin
        prev_pixel = color_index[data[5:0]];
        emit_pixel(1'b1);
      end else if (data < 8'd128) begin
        prev_pixel = {8'(r + {6'd0, data[5:4]} - 8'd2), 8'(g + {6'd0, data[3:2]} - 8'd2),
                      8'(b + {6'd0, data[1:0]} - 8'd2), a};
        emit_pixel(1'b1);
      end else if (data < 8'd192) begin
        pend       = PEND_LUMA;
        held_count = 1;
        held_bytes = {24'd0, data};
      end else begin
        // A run never goes past the image's last pixel.
        run_len = int'(data[5:0]) + 1;
        if (run_len > MAX_RUN) run_len = MAX_RUN;
        if (run_len > remaining) run_len = int'(remaining);
        for (int k = 0; k < run_len; k++) emit_pixel(k == run_len - 1);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Called once per accepted result transaction.
    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
      compare_field("last_of_image", want.last_of_image, got.last_of_image);
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic               clk               = 1'b0;
  logic               rst_n             = 1'b0;
  logic               cfg_we            = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata         = '0;
  logic               in_valid          = 1'b0;
  logic [7:0]         in_stream_byte    = 8'h00;
  logic               out_ready         = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [7:0]         out_alpha;
  logic               out_last_of_run;
  logic               out_last_of_image;

  decode_scoreboard sb = new();

  int bytes_sent = 0;
  int burst_left = 0;

  qoi_pixel_stream_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .out_last_of_run   (out_last_of_run),
    .out_last_of_image (out_last_of_image)
  );

  always #5 clk = ~clk;

  // The receiver picks one of four stall styles whenever rx_cycle[5:0] is zero:
  // always ready, coin toss, ready on a fixed quarter of the edges, and mostly
  // stalled. Values read at a rising edge are the ones the block sampled at that same edge.
  logic [31:0] rx_cycle = '0;
  int          rx_mode  = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle[5:0] == 6'd0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (rx_cycle[1:0] == 2'd0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 9) > 6);
      end
    endcase
  end

  // Every result transaction is checked against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_status, out_red, out_green, out_blue, out_alpha,
                       out_last_of_run, out_last_of_image});
    end
  end

  // Sends one byte. The sender works in bursts; a gap is opened only between
  // transactions, so valid is never dropped while a byte waits. Entered and
  // left at a rising edge.
  task automatic send_byte(input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_stream_byte <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(data);
    bytes_sent++;
  endtask

  // Waits until every owed result has arrived, then lets the block drain
  // bytes that cause nothing, so that a new image can be started safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_count(count);
  endtask

  // One well-formed chunk with random content, or now and then a stray byte.
  task automatic send_chunk();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 17) begin
      send_byte(BYTE_RGB);
      repeat (3) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 29) begin
      send_byte(BYTE_RGBA);
      repeat (4) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 44) begin
      // Mostly point at slots that hold a real pixel.
      if (sb.used_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
        send_byte(8'(sb.used_slots[$urandom_range(0, sb.used_slots.size() - 1)]));
      end else begin
        send_byte(8'($urandom_range(0, 63)));
      end
    end else if (pick < 62) begin
      send_byte(8'h40 | 8'($urandom_range(0, 63)));
    end else if (pick < 80) begin
      send_byte(8'h80 | 8'($urandom_range(0, 63)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      send_byte(8'hFD);
    end else begin
      send_byte(8'hC0 + 8'($urandom_range(0, 61)));
    end
  endtask

  // The end marker, sometimes with one byte spoiled, then a few stray bytes
  // that the block must swallow without a result.
  task automatic send_padding();
    bit         spoil;
    int         spot;
    logic [7:0] data;
    spoil = ($urandom_range(0, 9) < 3);
    spot  = $urandom_range(0, PAD_LEN - 1);
    for (int i = 0; i < PAD_LEN; i++) begin
      data = (i == PAD_LEN - 1) ? 8'd1 : 8'd0;
      if (spoil && i == spot) data = 8'($urandom_range(0, 255));
      send_byte(data);
    end
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int                 pick;
    int                 phase_start;
    logic [COUNT_W-1:0] count;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Right after reset the pixel count is zero, so the stream is the end
    // marker alone; one more byte after it must be ignored.
    repeat (PAD_LEN - 1) send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    settle();

    // One chunk of each kind at the corners of its fields: RGB keeps alpha,
    // RGBA sets alpha to zero, an index hit on the RGBA pixel, both extreme
    // differences and both extreme luma chunks. The longest run is then cut
    // at the last pixel, and an all-zero marker must report a mismatch.
    write_count(25'd9);
    send_byte(BYTE_RGB);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(BYTE_RGBA);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h22);
    send_byte(8'h40);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'hBF);
    send_byte(8'hFF);
    send_byte(8'hFD);
    repeat (PAD_LEN) send_byte(8'h00);
    settle();

    // Random images of assorted sizes. Most are decoded to the end and
    // closed with the marker; images too large to finish get a fixed byte
    // budget and are abandoned by the next pixel count write.
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        count = '0;
      end else if (pick < 20) begin
        count = 25'd1;
      end else if (pick < 30) begin
        count = ($urandom_range(0, 1) == 0) ? MAX_COUNT :
                25'($urandom_range(16777216, 1048576));
      end else if (pick < 45) begin
        count = 25'($urandom_range(60, 130));
      end else begin
        count = 25'($urandom_range(2, 40));
      end
      write_count(count);
      if (count > 25'd100000) begin
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < HUGE_IMAGE_BYTES) send_chunk();
      end else begin
        while (sb.remaining != 0) send_chunk();
        send_padding();
      end
      settle();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("qoi_pixel_stream_decoder test passed");
    end else begin
      $display("qoi_pixel_stream_decoder test failed");
    end
    $finish;
  end

  // Safety net far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("qoi_pixel_stream_decoder test failed");
    $finish;
  end

endmodule
